FILE: design/elevator_sorted_stop_lists_defines.svh
// assertion macros for the elevator stop list block
// used by the top level only; expects clk and rst_n in scope
`ifndef ELEVATOR_SORTED_STOP_LISTS_DEFINES_SVH
`define ELEVATOR_SORTED_STOP_LISTS_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define ESL_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define ESL_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/esl_pkg.sv
// shared types and constants for the elevator stop list block
// no dependencies
`timescale 1ns / 1ps

package esl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int FLOOR_BITS = 8;
    localparam int FILL_BITS  = $clog2(LIST_DEPTH + 1);
    localparam int COUNT_W    = 5;
    localparam int OPCODE_W   = 2;

    // request codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_MAIN    = 2'd0,
        OP_RESERVE = 2'd1,
        OP_CLEAR   = 2'd2
    } opcode_t;

    // one stop: floor and cabin-call flag
    typedef struct packed {
        logic signed [FLOOR_BITS-1:0] floor;
        logic                         inside_call;
    } entry_t;

endpackage

FILE: design/esl_cell.sv
// one cell of a sorted stop chain: holds a single entry
// depends on esl_pkg
`timescale 1ns / 1ps

module esl_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  logic            ascending,
    input  logic            valid,
    input  esl_pkg::entry_t key,
    input  esl_pkg::entry_t left_entry,
    input  logic            left_precedes,
    output esl_pkg::entry_t entry,
    output logic            precedes
);

    esl_pkg::entry_t entry_reg;
    esl_pkg::entry_t entry_next;

    // an entry stays ahead of the new key when it is held and not beyond it
    always_comb
    begin
        if (ascending)
            precedes = valid && (entry_reg.floor <= key.floor);
        else
            precedes = valid && (entry_reg.floor >= key.floor);
    end

    // keep, take the new key, or take the left neighbour's entry
    always_comb
    begin
        if (!shift_en || precedes)
            entry_next = entry_reg;
        else if (left_precedes)
            entry_next = key;
        else
            entry_next = left_entry;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: design/esl_chain.sv
// sorted stop list as a row of cells with a fill count
// depends on esl_pkg and esl_cell
`timescale 1ns / 1ps

module esl_chain (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           ascending,
    input  logic                           insert,
    input  logic                           clear,
    input  esl_pkg::entry_t                key,
    output esl_pkg::entry_t                head,
    output logic [esl_pkg::FILL_BITS-1:0]  fill,
    output logic                           full
);

    logic [esl_pkg::FILL_BITS-1:0] fill_reg;
    logic [esl_pkg::FILL_BITS-1:0] fill_next;

    esl_pkg::entry_t cell_entry [esl_pkg::LIST_DEPTH];
    logic            cell_prec  [esl_pkg::LIST_DEPTH];

    // row of cells, each looking at its left neighbour
    for (genvar i = 0; i < esl_pkg::LIST_DEPTH; i++)
    begin : g_cell
        esl_pkg::entry_t left_entry;
        logic            left_prec;
        logic            cell_valid;

        if (i == 0)
        begin : g_first
            assign left_entry = key;
            assign left_prec  = 1'b1;
        end
        else
        begin : g_rest
            assign left_entry = cell_entry[i-1];
            assign left_prec  = cell_prec[i-1];
        end

        assign cell_valid = fill_reg > esl_pkg::FILL_BITS'(i);

        esl_cell u_cell (
            .clk           (clk),
            .shift_en      (insert),
            .ascending     (ascending),
            .valid         (cell_valid),
            .key           (key),
            .left_entry    (left_entry),
            .left_precedes (left_prec),
            .entry         (cell_entry[i]),
            .precedes      (cell_prec[i])
        );
    end

    // fill count
    always_comb
    begin
        if (clear)
            fill_next = '0;
        else if (insert)
            fill_next = fill_reg + esl_pkg::FILL_BITS'(1);
        else
            fill_next = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    assign head = cell_entry[0];
    assign fill = fill_reg;
    assign full = fill_reg == esl_pkg::FILL_BITS'(esl_pkg::LIST_DEPTH);

endmodule

FILE: design/elevator_sorted_stop_lists.sv
// top level of the elevator stop lists: request decode, four sorted chains
// and the result register; depends on esl_pkg, esl_chain and the defines header
//
//  channel | signals                              | moves
//  in      | in_valid in_stall + request fields   | one request item
//  out     | out_valid out_stall + status fields  | one status item per request
//
// one request per cycle unless stalled; each result is registered after its request
// the rate is set by the insert of every cell chain in parallel
// reset clears all fill counts and sets the main order to ascending
// a waiting result holds the next request only while out_stall is high
`timescale 1ns / 1ps

`include "elevator_sorted_stop_lists_defines.svh"

module elevator_sorted_stop_lists (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [esl_pkg::OPCODE_W-1:0]          opcode,
    input  logic signed [esl_pkg::FLOOR_BITS-1:0] floor,
    input  logic                                  direction,
    input  logic                                  inside_call,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [esl_pkg::FLOOR_BITS-1:0] main_head_floor,
    output logic                                  main_head_inside,
    output logic [esl_pkg::COUNT_W-1:0]           main_count,
    output logic signed [esl_pkg::FLOOR_BITS-1:0] up_head_floor,
    output logic [esl_pkg::COUNT_W-1:0]           up_count,
    output logic signed [esl_pkg::FLOOR_BITS-1:0] down_head_floor,
    output logic [esl_pkg::COUNT_W-1:0]           down_count,
    output logic                                  main_empty,
    output logic                                  all_empty,
    output logic                                  overflow
);

    logic in_acc;
    logic out_load;
    logic is_main;
    logic is_reserve;
    logic is_clear;
    logic ins_main;
    logic ins_up;
    logic ins_down;
    logic ovf_now;

    esl_pkg::entry_t key;
    esl_pkg::entry_t asc_head;
    esl_pkg::entry_t desc_head;
    esl_pkg::entry_t up_head;
    esl_pkg::entry_t down_head;
    esl_pkg::entry_t main_head;

    logic [esl_pkg::FILL_BITS-1:0] asc_fill;
    logic [esl_pkg::FILL_BITS-1:0] desc_fill;
    logic [esl_pkg::FILL_BITS-1:0] up_fill;
    logic [esl_pkg::FILL_BITS-1:0] down_fill;
    logic asc_full;
    logic desc_full;
    logic up_full;
    logic down_full;

    logic order_up_reg;
    logic order_up_next;
    logic res_pend_reg;
    logic res_pend_next;
    logic ovf_pend_reg;
    logic ovf_pend_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic signed [esl_pkg::FLOOR_BITS-1:0] main_floor_reg;
    logic                                  main_inside_reg;
    logic [esl_pkg::COUNT_W-1:0]           main_count_reg;
    logic signed [esl_pkg::FLOOR_BITS-1:0] up_floor_reg;
    logic [esl_pkg::COUNT_W-1:0]           up_count_reg;
    logic signed [esl_pkg::FLOOR_BITS-1:0] down_floor_reg;
    logic [esl_pkg::COUNT_W-1:0]           down_count_reg;
    logic                                  main_empty_reg;
    logic                                  all_empty_reg;
    logic                                  overflow_reg;

    // handshake: the state may move on only once the pending status is captured
    assign out_load = res_pend_reg && (!out_valid_reg || !out_stall);
    assign in_stall = res_pend_reg && out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    // request decode
    assign is_main    = in_acc && (opcode == esl_pkg::OP_MAIN);
    assign is_reserve = in_acc && (opcode == esl_pkg::OP_RESERVE);
    assign is_clear   = in_acc && (opcode == esl_pkg::OP_CLEAR);
    assign ins_main   = is_main && !asc_full;
    assign ins_up     = is_reserve && direction && !up_full;
    assign ins_down   = is_reserve && !direction && !down_full;
    assign ovf_now    = (is_main && asc_full)
                     || (is_reserve && (direction ? up_full : down_full));

    assign key.floor       = floor;
    assign key.inside_call = inside_call;

    // main list kept in both orders so either head is ready at once
    esl_chain u_main_asc (
        .clk (clk), .rst_n (rst_n), .ascending (1'b1),
        .insert (ins_main), .clear (is_clear), .key (key),
        .head (asc_head), .fill (asc_fill), .full (asc_full)
    );

    esl_chain u_main_desc (
        .clk (clk), .rst_n (rst_n), .ascending (1'b0),
        .insert (ins_main), .clear (is_clear), .key (key),
        .head (desc_head), .fill (desc_fill), .full (desc_full)
    );

    esl_chain u_up (
        .clk (clk), .rst_n (rst_n), .ascending (1'b1),
        .insert (ins_up), .clear (is_clear), .key (key),
        .head (up_head), .fill (up_fill), .full (up_full)
    );

    esl_chain u_down (
        .clk (clk), .rst_n (rst_n), .ascending (1'b0),
        .insert (ins_down), .clear (is_clear), .key (key),
        .head (down_head), .fill (down_fill), .full (down_full)
    );

    assign main_head = order_up_reg ? asc_head : desc_head;

    // control next state
    always_comb
    begin
        order_up_next = ins_main ? direction : order_up_reg;
        ovf_pend_next = in_acc ? ovf_now : ovf_pend_reg;

        if (in_acc)
            res_pend_next = 1'b1;
        else if (out_load)
            res_pend_next = 1'b0;
        else
            res_pend_next = res_pend_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_up_reg  <= 1'b1;
            res_pend_reg  <= 1'b0;
            ovf_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            order_up_reg  <= order_up_next;
            res_pend_reg  <= res_pend_next;
            ovf_pend_reg  <= ovf_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // status register, loaded from the state left by the pending item
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            main_floor_reg  <= (asc_fill != '0) ? main_head.floor : '0;
            main_inside_reg <= (asc_fill != '0) ? main_head.inside_call : 1'b0;
            main_count_reg  <= esl_pkg::COUNT_W'(asc_fill);
            up_floor_reg    <= (up_fill != '0) ? up_head.floor : '0;
            up_count_reg    <= esl_pkg::COUNT_W'(up_fill);
            down_floor_reg  <= (down_fill != '0) ? down_head.floor : '0;
            down_count_reg  <= esl_pkg::COUNT_W'(down_fill);
            main_empty_reg  <= asc_fill == '0;
            all_empty_reg   <= (asc_fill == '0) && (up_fill == '0) && (down_fill == '0);
            overflow_reg    <= ovf_pend_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign main_head_floor  = main_floor_reg;
    assign main_head_inside = main_inside_reg;
    assign main_count       = main_count_reg;
    assign up_head_floor    = up_floor_reg;
    assign up_count         = up_count_reg;
    assign down_head_floor  = down_floor_reg;
    assign down_count       = down_count_reg;
    assign main_empty       = main_empty_reg;
    assign all_empty        = all_empty_reg;
    assign overflow         = overflow_reg;

    // checks
    `ESL_ASSERT_NOW(a_main_fill_match, 1'b1, (asc_fill == desc_fill) && (asc_full == desc_full), "main chains disagree on fill")
    `ESL_ASSERT_NOW(a_main_min_max, asc_fill != '0, asc_head.floor <= desc_head.floor, "main ascending head above descending head")
    `ESL_ASSERT_NEXT(a_main_drop, is_main && asc_full, ovf_pend_reg && $stable(asc_fill) && $stable(order_up_reg), "full main insert not dropped")
    `ESL_ASSERT_NEXT(a_clear, is_clear, (asc_fill == '0) && (up_fill == '0) && (down_fill == '0), "clear left entries")

endmodule

FILE: dv/tb_elevator_sorted_stop_lists.sv
// testbench for the elevator stop lists: directed, overflow, back-pressure and random requests
// depends on esl_pkg and elevator_sorted_stop_lists; keeps its own sorted-list predictor
`timescale 1ns / 1ps

module tb_elevator_sorted_stop_lists;

    import esl_pkg::*;

    // opcode that the block leaves unused
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic DIR_UP     = 1'b1;
    localparam logic DIR_DOWN   = 1'b0;
    localparam logic CALL_CABIN = 1'b1;
    localparam logic CALL_HALL  = 1'b0;
    localparam int LIST_MAIN = 0;
    localparam int LIST_UP   = 1;
    localparam int LIST_DOWN = 2;
    localparam logic signed [FLOOR_BITS-1:0] FLOOR_MAX = {1'b0, {(FLOOR_BITS-1){1'b1}}};
    localparam logic signed [FLOOR_BITS-1:0] FLOOR_MIN = {1'b1, {(FLOOR_BITS-1){1'b0}}};

    typedef struct {
        logic signed [FLOOR_BITS-1:0] main_head_floor;
        logic                         main_head_inside;
        logic [COUNT_W-1:0]           main_count;
        logic signed [FLOOR_BITS-1:0] up_head_floor;
        logic [COUNT_W-1:0]           up_count;
        logic signed [FLOOR_BITS-1:0] down_head_floor;
        logic [COUNT_W-1:0]           down_count;
        logic                         main_empty;
        logic                         all_empty;
        logic                         overflow;
    } status_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [OPCODE_W-1:0]          opcode;
    logic signed [FLOOR_BITS-1:0] floor;
    logic                         direction;
    logic                         inside_call;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [FLOOR_BITS-1:0] main_head_floor;
    logic                         main_head_inside;
    logic [COUNT_W-1:0]           main_count;
    logic signed [FLOOR_BITS-1:0] up_head_floor;
    logic [COUNT_W-1:0]           up_count;
    logic signed [FLOOR_BITS-1:0] down_head_floor;
    logic [COUNT_W-1:0]           down_count;
    logic                         main_empty;
    logic                         all_empty;
    logic                         overflow;

    // predicted stop lists and the status items still to come
    entry_t  stops [3][LIST_DEPTH];
    int      fill [3];
    status_t status_q [$];
    status_t want_status;

    int   mismatch_count = 0;
    int   hold_cycles    = 0;
    bit   sender_quiet   = 1'b0;
    bit   receiver_quiet = 1'b0;
    logic main_dir       = DIR_UP;

    elevator_sorted_stop_lists dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .floor            (floor),
        .direction        (direction),
        .inside_call      (inside_call),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .main_head_floor  (main_head_floor),
        .main_head_inside (main_head_inside),
        .main_count       (main_count),
        .up_head_floor    (up_head_floor),
        .up_count         (up_count),
        .down_head_floor  (down_head_floor),
        .down_count       (down_count),
        .main_empty       (main_empty),
        .all_empty        (all_empty),
        .overflow         (overflow)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // append a stop and re-sort the whole list stably; returns 1 when the list is full
    function automatic logic insert_stop(input int which, input logic signed [FLOOR_BITS-1:0] fl,
                                         input logic ins, input logic ascending);
        entry_t key;
        int     i;
        int     j;
        if (fill[which] >= LIST_DEPTH)
            return 1'b1;
        stops[which][fill[which]].floor       = fl;
        stops[which][fill[which]].inside_call = ins;
        fill[which]++;
        for (i = 1; i < fill[which]; i++)
        begin
            key = stops[which][i];
            j   = i;
            while (j > 0 && (ascending ? (key.floor < stops[which][j-1].floor)
                                       : (key.floor > stops[which][j-1].floor)))
            begin
                stops[which][j] = stops[which][j-1];
                j--;
            end
            stops[which][j] = key;
        end
        return 1'b0;
    endfunction

    // apply one accepted request to the predicted lists and queue its status
    function automatic void predict_status(input logic [OPCODE_W-1:0] op,
                                           input logic signed [FLOOR_BITS-1:0] fl,
                                           input logic dir, input logic ins);
        status_t s;
        logic    dropped;
        int      k;
        dropped = 1'b0;
        if (op == OP_MAIN)
            dropped = insert_stop(LIST_MAIN, fl, ins, dir);
        else if (op == OP_RESERVE)
        begin
            if (dir == DIR_UP)
                dropped = insert_stop(LIST_UP, fl, ins, 1'b1);
            else
                dropped = insert_stop(LIST_DOWN, fl, ins, 1'b0);
        end
        else if (op == OP_CLEAR)
        begin
            for (k = 0; k < 3; k++)
                fill[k] = 0;
        end
        s.main_head_floor  = fill[LIST_MAIN] != 0 ? stops[LIST_MAIN][0].floor : '0;
        s.main_head_inside = fill[LIST_MAIN] != 0 ? stops[LIST_MAIN][0].inside_call : 1'b0;
        s.main_count       = COUNT_W'(fill[LIST_MAIN]);
        s.up_head_floor    = fill[LIST_UP] != 0 ? stops[LIST_UP][0].floor : '0;
        s.up_count         = COUNT_W'(fill[LIST_UP]);
        s.down_head_floor  = fill[LIST_DOWN] != 0 ? stops[LIST_DOWN][0].floor : '0;
        s.down_count       = COUNT_W'(fill[LIST_DOWN]);
        s.main_empty       = fill[LIST_MAIN] == 0;
        s.all_empty        = fill[LIST_MAIN] == 0 && fill[LIST_UP] == 0 && fill[LIST_DOWN] == 0;
        s.overflow         = dropped;
        status_q.insert(status_q.size(), s);
    endfunction

    task automatic compare_field(input string name, input logic signed [8:0] want,
                                 input logic signed [8:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // check every status item taken from the block against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_q.size() == 0)
            begin
                $display("%0t: status item with no request pending", $time);
                mismatch_count++;
            end
            else
            begin
                want_status = status_q.pop_front();
                compare_field("main_head_floor", want_status.main_head_floor, main_head_floor);
                compare_field("main_head_inside", want_status.main_head_inside, main_head_inside);
                compare_field("main_count", want_status.main_count, main_count);
                compare_field("up_head_floor", want_status.up_head_floor, up_head_floor);
                compare_field("up_count", want_status.up_count, up_count);
                compare_field("down_head_floor", want_status.down_head_floor, down_head_floor);
                compare_field("down_count", want_status.down_count, down_count);
                compare_field("main_empty", want_status.main_empty, main_empty);
                compare_field("all_empty", want_status.all_empty, all_empty);
                compare_field("overflow", want_status.overflow, overflow);
            end
        end
    end

    // receiver: random stalls, long hold-offs on request, quiet stretches
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else if (receiver_quiet)
                out_stall = 1'b0;
            else
                out_stall = $urandom_range(99) < 8;
        end
    end

    // floors bunched around the ground floor so that ties are common
    function automatic logic signed [FLOOR_BITS-1:0] pick_floor();
        int v;
        case ($urandom_range(9))
            0:       return FLOOR_MAX;
            1:       return FLOOR_MIN;
            2, 3, 4: return FLOOR_BITS'($urandom_range(255));
            default:
            begin
                v = int'($urandom_range(16)) - 4;
                return FLOOR_BITS'(v);
            end
        endcase
    endfunction

    // offer one request item, starting and ending at a falling edge
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic signed [FLOOR_BITS-1:0] fl,
                                input logic dir, input logic ins);
        int gap;
        if (!sender_quiet && $urandom_range(99) < 8)
        begin
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        opcode      = op;
        floor       = fl;
        direction   = dir;
        inside_call = ins;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_status(op, fl, dir, ins);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // random request, mostly inserts; the main direction changes now and then so the list gets re-sorted
    task automatic send_random_request();
        int r;
        r = $urandom_range(99);
        if ($urandom_range(3) == 0)
            main_dir = ~main_dir;
        if (r < 3)
            send_request(OP_UNUSED, pick_floor(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        else if (r < 50)
            send_request(OP_MAIN, pick_floor(), main_dir, 1'($urandom_range(1)));
        else
            send_request(OP_RESERVE, pick_floor(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // extremes, every opcode, ties, direction change and clear
    task automatic test_directed();
        send_request(OP_UNUSED, -8'sd1, DIR_UP, CALL_CABIN);
        send_request(OP_MAIN, 8'sd5, DIR_UP, CALL_HALL);
        send_request(OP_MAIN, FLOOR_MAX, DIR_UP, CALL_CABIN);
        send_request(OP_MAIN, FLOOR_MIN, DIR_UP, CALL_HALL);
        send_request(OP_MAIN, FLOOR_MIN, DIR_UP, CALL_CABIN);
        send_request(OP_MAIN, 8'sd5, DIR_UP, CALL_CABIN);
        send_request(OP_MAIN, 8'sd0, DIR_DOWN, CALL_CABIN);
        send_request(OP_MAIN, FLOOR_MAX, DIR_DOWN, CALL_HALL);
        send_request(OP_MAIN, -8'sd3, DIR_UP, CALL_HALL);
        send_request(OP_RESERVE, FLOOR_MAX, DIR_UP, CALL_CABIN);
        send_request(OP_RESERVE, FLOOR_MIN, DIR_UP, CALL_HALL);
        send_request(OP_RESERVE, FLOOR_MIN, DIR_UP, CALL_CABIN);
        send_request(OP_RESERVE, FLOOR_MIN, DIR_DOWN, CALL_HALL);
        send_request(OP_RESERVE, FLOOR_MAX, DIR_DOWN, CALL_CABIN);
        send_request(OP_RESERVE, FLOOR_MAX, DIR_DOWN, CALL_HALL);
        send_request(OP_UNUSED, FLOOR_MIN, DIR_DOWN, CALL_HALL);
        send_request(OP_CLEAR, FLOOR_MAX, DIR_UP, CALL_CABIN);
        send_request(OP_MAIN, -8'sd1, DIR_DOWN, CALL_CABIN);
        send_request(OP_RESERVE, 8'sd0, DIR_DOWN, CALL_HALL);
        send_request(OP_RESERVE, 8'sd0, DIR_UP, CALL_CABIN);
        send_request(OP_CLEAR, 8'sd0, DIR_DOWN, CALL_HALL);
    endtask

    // fill each list and push one more insert into it
    task automatic test_list_overflow();
        repeat (LIST_DEPTH + 1)
            send_request(OP_MAIN, pick_floor(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (LIST_DEPTH + 1)
            send_request(OP_RESERVE, pick_floor(), DIR_UP, 1'($urandom_range(1)));
        repeat (LIST_DEPTH + 1)
            send_request(OP_RESERVE, pick_floor(), DIR_DOWN, 1'($urandom_range(1)));
        send_request(OP_UNUSED, pick_floor(), DIR_UP, CALL_HALL);
        send_request(OP_CLEAR, pick_floor(), DIR_DOWN, CALL_CABIN);
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_hold();
        sender_quiet = 1'b1;
        hold_cycles  = 80;
        repeat (40)
            send_random_request();
        sender_quiet = 1'b0;
        send_request(OP_CLEAR, pick_floor(), DIR_UP, CALL_HALL);
    endtask

    // sender stops until every status item has come back
    task automatic test_drain_pause();
        repeat (20)
            send_random_request();
        while (status_q.size() != 0)
            @(negedge clk);
        repeat (20)
            send_random_request();
        send_request(OP_CLEAR, pick_floor(), DIR_DOWN, CALL_HALL);
    endtask

    // bursts of inserts, each closed by a clear
    task automatic test_random_traffic(input int n_items, input bit quiet);
        int sent;
        int burst;
        sender_quiet   = quiet;
        receiver_quiet = quiet;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(4, 55);
            repeat (burst)
                send_random_request();
            send_request(OP_CLEAR, pick_floor(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            sent += burst + 1;
        end
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    // reset, test sequence and final verdict
    initial
    begin
        int k;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OP_MAIN;
        floor       = '0;
        direction   = DIR_DOWN;
        inside_call = CALL_HALL;
        for (k = 0; k < 3; k++)
            fill[k] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_list_overflow();
        test_output_hold();
        test_drain_pause();
        test_random_traffic(1200, 1'b0);
        test_random_traffic(200, 1'b1);

        while (status_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
